### hdl/sdta_pkg.sv
`timescale 1ns / 1ps
// sdta_pkg: shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies.
package sdta_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // double-dabble digit correction
  localparam logic [3:0] DD_THRESH = 4'd5;
  localparam logic [3:0] DD_ADD    = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } back_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } out_char_t;

endpackage

### hdl/sdta_fifo.sv
`timescale 1ns / 1ps
// sdta_fifo: small synchronous queue with push/full and pop/empty.
// No dependencies.
module sdta_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hdl/sdta_front.sv
`timescale 1ns / 1ps
// sdta_front: input stage; registers each item as sign flag plus magnitude.
// No dependencies; its output feeds the item queue.
module sdta_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  q_push,
  input  logic                  q_full,
  output logic [VALUE_BITS:0]   q_data
);

  logic                  valid_r, valid_nxt;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic                  take;

  assign in_full   = valid_r && q_full;
  assign take      = in_push && !in_full;
  assign q_push    = valid_r;
  assign q_data    = {neg_r, mag_r};
  assign valid_nxt = take || (valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // most negative value negates to 2**(VALUE_BITS-1), exact as unsigned
  always_ff @(posedge clk) begin
    if (take) begin
      neg_r <= in_value[VALUE_BITS-1];
      mag_r <= in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
    end
  end

endmodule

### hdl/sdta_back.sv
`timescale 1ns / 1ps
// sdta_back: double-dabble conversion and character emission.
// Depends on sdta_pkg.
module sdta_back
  import sdta_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic [VALUE_BITS:0] q_data,
  output logic                o_push,
  input  logic                o_full,
  output out_char_t           o_data
);

  localparam int NDIG = (VALUE_BITS * 301) / 1000 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int CW   = $clog2(VALUE_BITS + 1);
  localparam int RW   = $clog2(NDIG + 1);
  localparam logic [CW-1:0] CNT_LOAD = CW'(VALUE_BITS);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [RW-1:0] REM_LOAD = RW'(NDIG);
  localparam logic [RW-1:0] REM_ONE  = RW'(1);

  back_state_t           state_r, state_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BW-1:0]         bcd_r, bcd_nxt;
  logic [BW-1:0]         bcd_adj;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic [3:0]            top_dig;
  logic                  last_dig;

  assign top_dig  = bcd_r[BW-1 -: 4];
  assign last_dig = (rem_r == REM_ONE);

  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= DD_THRESH) ?
                          bcd_r[4*d +: 4] + DD_ADD : bcd_r[4*d +: 4];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (!q_empty) state_nxt = ST_CONV;
      ST_CONV:  if (cnt_r == CNT_ONE) state_nxt = ST_SKIP;
      ST_SKIP: begin
        if (top_dig != '0 || last_dig) begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN:  if (!o_full) state_nxt = ST_DIGIT;
      ST_DIGIT: if (!o_full && last_dig) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop            = 1'b0;
    o_push           = 1'b0;
    o_data.char_code = CHAR_ZERO + {4'b0, top_dig};
    o_data.is_last   = last_dig;
    case (state_r)
      ST_IDLE:  q_pop = !q_empty;
      ST_SIGN: begin
        o_push           = !o_full;
        o_data.char_code = CHAR_MINUS;
        o_data.is_last   = 1'b0;
      end
      ST_DIGIT: o_push = !o_full;
      default:  ;
    endcase
  end

  // datapath
  always_comb begin
    neg_nxt = neg_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    case (state_r)
      ST_IDLE: begin
        neg_nxt = q_data[VALUE_BITS];
        bin_nxt = q_data[VALUE_BITS-1:0];
        bcd_nxt = '0;
        cnt_nxt = CNT_LOAD;
      end
      ST_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[BW-2:0], bin_r, 1'b0};
        cnt_nxt = cnt_r - CNT_ONE;
        rem_nxt = REM_LOAD;
      end
      ST_SKIP: begin
        if (top_dig == '0 && !last_dig) begin
          bcd_nxt = {bcd_r[BW-5:0], 4'b0};
          rem_nxt = rem_r - REM_ONE;
        end
      end
      ST_DIGIT: begin
        if (!o_full) begin
          bcd_nxt = {bcd_r[BW-5:0], 4'b0};
          rem_nxt = rem_r - REM_ONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
  end

endmodule

### hdl/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// signed_int_to_decimal_ascii_unit: signed integer in, decimal ASCII characters out.
// The back end takes one item at a time: it pops it, shifts once per bit, skips leading zero
// digits (NDIG = decimal digits of 2**VALUE_BITS), then emits an optional minus sign and the
// digits, stalling while the output queue is full; it pops the next item only when idle.
// Reset: synchronous active-low rst_n empties all queues and idles the converter.
module signed_int_to_decimal_ascii_unit
  import sdta_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [7:0]            out_char_code,
  output logic                  out_is_last
);

  localparam int QW = VALUE_BITS + 1;

  logic          fq_push, fq_full, q_empty, q_pop;
  logic [QW-1:0] fq_data, q_data;
  logic          o_push, o_full;
  out_char_t     o_data, o_rdata;

  sdta_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .q_push   (fq_push),
    .q_full   (fq_full),
    .q_data   (fq_data)
  );

  sdta_fifo #(.W(QW), .DEPTH(2)) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (fq_data),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_data)
  );

  sdta_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .o_push  (o_push),
    .o_full  (o_full),
    .o_data  (o_data)
  );

  sdta_fifo #(.W($bits(out_char_t)), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .full  (o_full),
    .wdata (o_data),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (o_rdata)
  );

  assign out_char_code = o_rdata.char_code;
  assign out_is_last   = o_rdata.is_last;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> !o_full) else $error("character transfer into full output queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("item taken from empty queue");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> (o_data.char_code == CHAR_MINUS) ||
               (o_data.char_code >= CHAR_ZERO && o_data.char_code <= CHAR_NINE))
    else $error("character outside sign and digit set");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (o_push && o_data.char_code == CHAR_MINUS) |-> !o_data.is_last)
    else $error("minus sign marked as last character");

endmodule

### test/signed_int_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for signed_int_to_decimal_ascii_unit: signed 32-bit values in, decimal ASCII out.
// A directed table and random values are checked character by character against a
// local itoa predictor. Depends on sdta_pkg and the unit itself.
module signed_int_to_decimal_ascii_unit_tb
  import sdta_pkg::*;
();

  localparam int VALUE_BITS   = 32;
  localparam int HOLD_CYCLES  = 500;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 107;
  localparam int DIR_N        = 16;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_push  = 1'b0;
  logic                  in_full;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_empty;
  logic                  out_pop  = 1'b0;
  logic [7:0]            out_char_code;
  logic                  out_is_last;

  // directed values; a non-empty text is the literal expected output
  logic [VALUE_BITS-1:0] dir_value [DIR_N] = '{
    32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
    32'd10, -32'd10, 32'd99, 32'd100, 32'd1000000000, -32'd999999999, 32'd1999999999,
    -32'd67890
  };
  string dir_text [DIR_N] = '{
    "0", "1", "-1", "9", "-9", "2147483647", "-2147483648", "-2147483647",
    "", "", "", "", "", "", "", ""
  };

  out_char_t   pending_chars [$];
  out_char_t   want;
  string       next_text = "";
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  bit          hold_req     = 1'b0;
  int unsigned fail_count   = 0;
  int unsigned stall_cycles = 0;
  int unsigned items_in     = 0;
  int unsigned negatives_in = 0;
  int unsigned chars_out    = 0;
  int unsigned full_cycles  = 0;
  int unsigned pow10 [10];

  signed_int_to_decimal_ascii_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_value     (in_value),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_char_code(out_char_code),
    .out_is_last  (out_is_last)
  );

  always #5 clk = ~clk;

  function automatic void predict_text(input logic [VALUE_BITS-1:0] word);
    logic [VALUE_BITS:0] mag;
    logic [7:0]          digits [$];
    mag = word[VALUE_BITS-1] ? ('0 - {1'b1, word}) : {1'b0, word};
    do begin
      digits.push_front(CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (word[VALUE_BITS-1]) begin
      pending_chars.push_back(out_char_t'{char_code: CHAR_MINUS, is_last: 1'b0});
    end
    foreach (digits[i]) begin
      pending_chars.push_back(out_char_t'{char_code: digits[i],
                                          is_last: (i == digits.size() - 1)});
    end
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back(out_char_t'{char_code: 8'(s[i]), is_last: (i == s.len() - 1)});
    end
  endfunction

  function automatic void flag_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value();
    int unsigned     sel;
    int unsigned     k;
    logic [31:0]     v;
    sel = $urandom_range(0, 9);
    k   = $urandom_range(1, 9);
    if (sel < 4) begin
      v = $urandom;
    end else if (sel < 7) begin
      v = $urandom_range(0, pow10[k] - 1);
    end else if (sel < 9) begin
      v = pow10[k] - $urandom_range(0, 1);
    end else begin
      v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                               : 32'h7FFF_FFFF - $urandom_range(0, 3);
    end
    if (sel >= 4 && $urandom_range(0, 1)) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic offer_value(input logic [VALUE_BITS-1:0] v, input string txt);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_push  = 1'b0;
      in_value = $urandom;
      @(negedge clk);
    end
    in_push   = 1'b1;
    in_value  = v;
    next_text = txt;
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain_pending();
    @(negedge clk);
    in_push = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // receiver: random pop, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_pop = ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // transfer monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        if (next_text == "") begin
          predict_text(in_value);
        end else begin
          queue_text(next_text);
        end
        items_in++;
        if (in_value[VALUE_BITS-1]) negatives_in++;
      end
      if (in_push && in_full) full_cycles++;
      if (out_pop && !out_empty) begin
        chars_out++;
        if (pending_chars.size() == 0) begin
          flag_mismatch($sformatf("unexpected char %0d last %0b", out_char_code, out_is_last));
        end else begin
          want = pending_chars.pop_front();
          if (want.char_code != out_char_code || want.is_last != out_is_last) begin
            flag_mismatch($sformatf("char exp %0d got %0d, last exp %0b got %0b",
                                    want.char_code, out_char_code, want.is_last, out_is_last));
          end
        end
      end
      stall_cycles <= ((in_push && !in_full) || (out_pop && !out_empty)) ? 0
                                                                          : stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("signed_int_to_decimal_ascii_unit verification failed");
    $finish;
  end

  initial begin
    pow10[0] = 1;
    for (int i = 1; i < 10; i++) pow10[i] = pow10[i-1] * 10;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_gap_pct = 11;
    recv_gap_pct = 52;
    for (int i = 0; i < DIR_N; i++) offer_value(dir_value[i], dir_text[i]);
    drain_pending();

    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2) hold_req = 1'b1;
      offer_value(random_value(), "");
    end
    drain_pending();

    send_gap_pct = 52;
    recv_gap_pct = 11;
    for (int i = 0; i < PHASE_ITEMS; i++) offer_value(random_value(), "");
    drain_pending();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) offer_value(random_value(), "");
    drain_pending();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_chars.size() != 0) begin
      flag_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));
    end
    $display("converted %0d values (%0d negative) into %0d characters",
             items_in, negatives_in, chars_out);
    $display("input held off by full for %0d cycles, %0d mismatches", full_cycles, fail_count);
    if (fail_count == 0) begin
      $display("signed_int_to_decimal_ascii_unit verification clean");
    end else begin
      $display("signed_int_to_decimal_ascii_unit verification failed");
    end
    $finish;
  end

endmodule
